// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// types and fixed codes of the open addressing hash table core
// ----------------------------------------------------------------------------
package oaht_pkg;

  // result field widths
  localparam int STATUS_W = 3;
  localparam int LOC_W    = 6;
  localparam int PROBES_W = 7;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  // probe sequence codes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  // slot tags
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_USED  = 2'd1;
  localparam logic [1:0] TAG_GONE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

  // register index (word address bit)
  localparam logic REG_PROBE_MODE = 1'b0;

  // base of the double hashing step
  localparam logic [2:0] DH_BASE = 3'd7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_BACK,
    S_FIX,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  // remainder passes of the shared unit
  typedef enum logic [1:0] {
    PASS_HOME,
    PASS_BASE,
    PASS_SLOT
  } pass_t;

endpackage

// File: src/open_addressing_hash_table_core.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// open addressing hash table with linear, quadratic or double hash probing
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_func, in_key) is taken when in_valid is high and in_stall
//   is low. in_stall stays high while a request is in work, so one request
//   is handled at a time. Each request gives exactly one result
//   (out_status, out_location, out_probes), shown while out_valid is high
//   and taken when out_stall is low; a stalled result holds.
//   Operation: one shared multiplier with a subtract and correct step finds
//   key mod PRIME, key mod 7 and home mod SLOTS by reciprocal
//   multiplication, each pass in the steps S_MUL, S_BACK and S_FIX. Each
//   probe then takes a registered read of the slot memory (S_READ) and a
//   compare and update (S_CHECK). After the last probe the output register
//   loads in S_DONE once it is free, and the core goes back to idle; the
//   pace of requests is set by the probe count and the single memory port.
//   Reset: rst_n is synchronous. After reset a clearing pass tags every
//   slot empty, one by one; in_stall is high meanwhile. The probe_mode
//   register (APB, byte address 0) may be written at any time while idle.
//   If the receiver stalls, a finished result waits in the core until the
//   output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module open_addressing_hash_table_core #(
  parameter int SLOTS    = 64,
  parameter int PRIME    = 61,
  parameter int KEY_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic [KEY_BITS-1:0]              in_key,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [oaht_pkg::STATUS_W-1:0]    out_status,
  output logic [oaht_pkg::LOC_W-1:0]       out_location,
  output logic [oaht_pkg::PROBES_W-1:0]    out_probes,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import oaht_pkg::*;

  localparam int SW     = $clog2(SLOTS);
  localparam int PW     = $clog2(PRIME);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int DMAX   = (PRIME > SLOTS) ? PRIME : SLOTS;
  localparam int DW     = $clog2(DMAX + 1);
  localparam int OW     = (KEY_BITS > DW) ? KEY_BITS : DW;
  localparam int EW     = KEY_BITS + 2;
  localparam int PM     = PRIME % SLOTS;
  localparam int DW_ADJ = SLOTS - PM;

  localparam logic [PW:0] PRIME_P = (PW + 1)'(PRIME);
  localparam logic [SW:0] SLOTS_S = (SW + 1)'(SLOTS);
  localparam logic [SW:0] ADJ_S   = (SW + 1)'(DW_ADJ);

  // reciprocals floor(2^KEY_BITS / d) and divisors of the remainder unit
  localparam logic [63:0]   KEY_SPAN  = 64'd1 << KEY_BITS;
  localparam logic [OW-1:0] RCP_PRIME = OW'(KEY_SPAN / 64'(PRIME));
  localparam logic [OW-1:0] RCP_BASE  = OW'(KEY_SPAN / 64'(DH_BASE));
  localparam logic [OW-1:0] RCP_SLOTS = OW'(KEY_SPAN / 64'(SLOTS));
  localparam logic [OW-1:0] DIV_PRIME = OW'(PRIME);
  localparam logic [OW-1:0] DIV_BASE  = OW'(DH_BASE);
  localparam logic [OW-1:0] DIV_SLOTS = OW'(SLOTS);

  // slot memory: {tag, key}
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] mem_rd_r;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  // control and work registers
  state_t                state_r, state_nxt;
  pass_t                 pass_r, pass_nxt;
  logic [1:0]            probe_mode_r, probe_mode_nxt;
  logic [SW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [1:0]            func_r, func_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [2*OW-1:0]       prod_r, prod_nxt;
  logic [2:0]            k7_r, k7_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [SW-1:0]         d_r, d_nxt;
  logic [SW-1:0]         awrap_r, awrap_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [SW-1:0]         res_loc_r, res_loc_nxt;
  logic [CW-1:0]         res_probes_r, res_probes_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [LOC_W-1:0]      out_location_r, out_location_nxt;
  logic [PROBES_W-1:0]   out_probes_r, out_probes_nxt;

  // shared remainder unit
  logic [OW-1:0]   div_x;
  logic [OW-1:0]   div_d;
  logic [OW-1:0]   div_m;
  logic [OW-1:0]   mul_a;
  logic [OW-1:0]   mul_b;
  logic [2*OW-1:0] mul_p;
  logic [OW-1:0]   quo;
  logic [OW-1:0]   fix_t;
  logic [OW-1:0]   fix_rem;
  logic [2:0]      step2;

  // slot step unit
  logic [SW-1:0] slot_add;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot_q;
  logic [SW:0]   d_sum;
  logic [SW-1:0] d_q;
  logic [PW:0]   p_sum;
  logic          p_wrap;
  logic [PW-1:0] p_q;
  logic [SW:0]   a_sum;
  logic [SW-1:0] a_q;

  // slot check
  logic [1:0]          rd_tag;
  logic [KEY_BITS-1:0] rd_key;
  logic                rd_hit;
  logic                probe_stop;
  logic                probe_write;
  logic [1:0]          probe_tag;
  logic [STATUS_W-1:0] probe_status;

  logic [SW+LOC_W-1:0]    loc_wide;
  logic [CW+PROBES_W-1:0] probes_wide;
  logic                   cfg_wr;

  // operands of the current pass
  always_comb begin
    case (pass_r)
      PASS_HOME: begin
        div_x = OW'(key_r);
        div_d = DIV_PRIME;
        div_m = RCP_PRIME;
      end
      PASS_BASE: begin
        div_x = OW'(key_r);
        div_d = DIV_BASE;
        div_m = RCP_BASE;
      end
      default: begin
        div_x = OW'(p_r);
        div_d = DIV_SLOTS;
        div_m = RCP_SLOTS;
      end
    endcase
  end

  // one multiplier: x times reciprocal, then quotient estimate times divisor
  assign quo   = OW'(prod_r >> KEY_BITS);
  assign mul_a = (state_r == S_BACK) ? quo : div_x;
  assign mul_b = (state_r == S_BACK) ? div_d : div_m;
  assign mul_p = (2*OW)'(mul_a) * (2*OW)'(mul_b);

  // estimate is low by at most one, one correcting subtract
  assign fix_t   = div_x - prod_r[OW-1:0];
  assign fix_rem = (fix_t >= div_d) ? fix_t - div_d : fix_t;

  // double hashing step
  assign step2 = DH_BASE - k7_r;

  // double hashing: next position mod PRIME
  assign p_sum  = {1'b0, p_r} + (PW + 1)'(step2);
  assign p_wrap = (p_sum >= PRIME_P);
  assign p_q    = p_wrap ? PW'(p_sum - PRIME_P) : PW'(p_sum);

  // slot offset when the PRIME sequence wraps: step2 - PRIME, mod SLOTS
  assign a_sum = (SW + 1)'(step2) + ADJ_S;
  assign a_q   = (a_sum >= SLOTS_S) ? SW'(a_sum - SLOTS_S) : SW'(a_sum);

  // slot advance, one add and compare per probe
  always_comb begin
    case (probe_mode_r)
      MODE_QUAD:   slot_add = d_r;
      MODE_DOUBLE: slot_add = p_wrap ? awrap_r : SW'(step2);
      default:     slot_add = SW'(1);
    endcase
  end
  assign slot_sum = {1'b0, slot_r} + {1'b0, slot_add};
  assign slot_q   = (slot_sum >= SLOTS_S) ? SW'(slot_sum - SLOTS_S) : SW'(slot_sum);

  // quadratic increment 2i+1 mod SLOTS
  assign d_sum = {1'b0, d_r} + (SW + 1)'(2);
  assign d_q   = (d_sum >= SLOTS_S) ? SW'(d_sum - SLOTS_S) : SW'(d_sum);

  // examine the slot just read
  assign rd_tag = mem_rd_r[EW-1 -: 2];
  assign rd_key = mem_rd_r[KEY_BITS-1:0];
  assign rd_hit = (rd_tag == TAG_USED) && (rd_key == key_r);
  always_comb begin
    probe_stop   = 1'b0;
    probe_write  = 1'b0;
    probe_tag    = TAG_USED;
    probe_status = STAT_NOT_FOUND;
    if (func_r == FUNC_INSERT) begin
      if (rd_tag == TAG_EMPTY || rd_tag == TAG_GONE) begin
        probe_stop   = 1'b1;
        probe_write  = 1'b1;
        probe_tag    = TAG_USED;
        probe_status = STAT_INSERTED;
      end else if (rd_hit) begin
        probe_stop   = 1'b1;
        probe_status = STAT_DUPLICATE;
      end
    end else begin
      if (rd_tag == TAG_EMPTY) begin
        probe_stop   = 1'b1;
        probe_status = STAT_NOT_FOUND;
      end else if (rd_hit) begin
        probe_stop = 1'b1;
        if (func_r == FUNC_DELETE) begin
          probe_write  = 1'b1;
          probe_tag    = TAG_GONE;
          probe_status = STAT_DELETED;
        end else begin
          probe_status = STAT_FOUND;
        end
      end
    end
  end

  // result fields cut to their port widths
  assign loc_wide    = {{LOC_W{1'b0}}, res_loc_r};
  assign probes_wide = {{PROBES_W{1'b0}}, res_probes_r};

  // configuration write
  assign cfg_wr = psel && penable && pwrite && pready;

  // sequencer: next state and work registers
  always_comb begin
    state_nxt        = state_r;
    pass_nxt         = pass_r;
    probe_mode_nxt   = probe_mode_r;
    clr_idx_nxt      = clr_idx_r;
    func_nxt         = func_r;
    key_nxt          = key_r;
    prod_nxt         = prod_r;
    k7_nxt           = k7_r;
    p_nxt            = p_r;
    slot_nxt         = slot_r;
    d_nxt            = d_r;
    awrap_nxt        = awrap_r;
    cnt_nxt          = cnt_r;
    res_status_nxt   = res_status_r;
    res_loc_nxt      = res_loc_r;
    res_probes_nxt   = res_probes_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_location_nxt = out_location_r;
    out_probes_nxt   = out_probes_r;
    mem_we           = 1'b0;
    mem_waddr        = slot_r;
    mem_wdata        = {probe_tag, key_r};

    if (cfg_wr && paddr[2] == REG_PROBE_MODE) begin
      probe_mode_nxt = pwdata[1:0];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = {TAG_EMPTY, {KEY_BITS{1'b0}}};
        clr_idx_nxt = clr_idx_r + SW'(1);
        if (clr_idx_r == SW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          key_nxt   = in_key;
          pass_nxt  = PASS_HOME;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_BACK;
      end
      S_BACK: begin
        prod_nxt  = mul_p;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        case (pass_r)
          PASS_HOME: begin
            p_nxt     = PW'(fix_rem);
            pass_nxt  = PASS_BASE;
            state_nxt = S_MUL;
          end
          PASS_BASE: begin
            k7_nxt    = 3'(fix_rem);
            pass_nxt  = PASS_SLOT;
            state_nxt = S_MUL;
          end
          default: begin
            slot_nxt  = SW'(fix_rem);
            d_nxt     = SW'(1);
            cnt_nxt   = '0;
            awrap_nxt = a_q;
            state_nxt = S_READ;
          end
        endcase
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (probe_stop) begin
          mem_we         = probe_write;
          res_status_nxt = probe_status;
          res_loc_nxt    = (probe_status == STAT_NOT_FOUND) ? '0 : slot_r;
          res_probes_nxt = cnt_r + CW'(1);
          state_nxt      = S_DONE;
        end else if (cnt_r == CW'(SLOTS - 1)) begin
          // probe limit reached
          res_status_nxt = (func_r == FUNC_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
          res_loc_nxt    = '0;
          res_probes_nxt = CW'(SLOTS);
          state_nxt      = S_DONE;
        end else begin
          slot_nxt  = slot_q;
          d_nxt     = d_q;
          p_nxt     = p_q;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = res_status_r;
          out_location_nxt = loc_wide[LOC_W-1:0];
          out_probes_nxt   = probes_wide[PROBES_W-1:0];
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      probe_mode_r <= MODE_LINEAR;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      probe_mode_r <= probe_mode_nxt;
      clr_idx_r    <= clr_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // work and payload registers
  always_ff @(posedge clk) begin
    pass_r         <= pass_nxt;
    func_r         <= func_nxt;
    key_r          <= key_nxt;
    prod_r         <= prod_nxt;
    k7_r           <= k7_nxt;
    p_r            <= p_nxt;
    slot_r         <= slot_nxt;
    d_r            <= d_nxt;
    awrap_r        <= awrap_nxt;
    cnt_r          <= cnt_nxt;
    res_status_r   <= res_status_nxt;
    res_loc_r      <= res_loc_nxt;
    res_probes_r   <= res_probes_nxt;
    out_status_r   <= out_status_nxt;
    out_location_r <= out_location_nxt;
    out_probes_r   <= out_probes_nxt;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[slot_r];
  end

  // ports
  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_location = out_location_r;
  assign out_probes   = out_probes_r;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_PROBE_MODE) ? {30'd0, probe_mode_r} : 32'd0;

  // checks
  `CHK_IMPLY(a_check_after_read, state_r == S_CHECK, $past(state_r) == S_READ, "check without read")
  `CHK_IMPLY(a_slot_range, state_r == S_READ, slot_r < SLOTS, "probe slot out of range")
  `CHK_IMPLY(a_prime_range, state_r == S_READ, p_r < PRIME, "hash position out of range")
  `CHK_IMPLY(a_result_source, $rose(out_valid_r), $past(state_r) == S_DONE, "result without item")

endmodule
